// ----- sv/tcce_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine: screen size,
// operation and control codes, and the command and response items.
// ---------------------------------------------------------------------------
package tcce_pkg;

    localparam int ROWS    = 25;
    localparam int COLUMNS = 80;
    localparam int NCELLS  = ROWS * COLUMNS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 2 * BYTE_W;
    localparam int ADDR_W = $clog2(NCELLS);

    localparam logic [2:0] OP_PUT   = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_DRAW  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [BYTE_W-1:0] RESET_COLOR = 8'd7;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [BYTE_W-1:0] char_code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [BYTE_W-1:0] draw_color;
    } cmd_t;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] cell_char;
        logic [BYTE_W-1:0] cell_color;
        logic [ROW_W-1:0]  cursor_row_now;
        logic [COL_W-1:0]  cursor_col_now;
    } rsp_t;

endpackage
`default_nettype wire

// ----- sv/text_console_cursor_engine_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Text-mode screen store with a logical cursor. The cells live in one
// synchronous memory; a sequencer reads, modifies and writes it back.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Item
//  cmd      in         cmd_valid / cmd_ready   tcce_pkg::cmd_t
//  rsp      out        rsp_valid / rsp_ready   tcce_pkg::rsp_t
//  cfg      in         cfg_we                  text colour byte
//
// A put byte and a draw in range pass the execute, write and done states; a read
// in range passes execute, read and done; a set cursor, an out-of-range position
// and an unused code pass execute and done. A scroll moves the rows up and blanks
// the last, and a clear blanks every cell, one cell per cycle through the single
// write port of the cell memory. After reset the memory is blanked, during which
// no item is accepted; configuration writes are taken throughout.
// A new item is accepted while a response still waits to be taken; the next
// one then stalls in its last cycle until that response is taken.
module text_console_cursor_engine_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cmd_valid,
    output logic                                cmd_ready,
    input  wire tcce_pkg::cmd_t                 cmd,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output tcce_pkg::rsp_t                      rsp,
    input  wire logic                           cfg_we,
    input  wire logic [tcce_pkg::BYTE_W-1:0]    cfg_wdata
);
    import tcce_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL,
        S_BLANK,
        S_WRITE,
        S_DONE
    } state_t;

    localparam logic [ROW_W-1:0]  ROWS_V     = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COLS_V     = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(NCELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(NCELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(int'(r) * COLUMNS + int'(c));
    endfunction

    logic [CELL_W-1:0] mem [NCELLS];
    logic [CELL_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [BYTE_W-1:0] text_color_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [CELL_W-1:0] pend_data_reg;
    logic              status_reg;
    logic [BYTE_W-1:0] rch_reg;
    logic [BYTE_W-1:0] rcol_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic              pos_ok;
    logic              is_bs;
    logic              is_nl;
    logic              is_cr;
    logic [ROW_W-1:0]  bs_row;
    logic [COL_W-1:0]  bs_col;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;
    logic              put_scroll;
    logic [ROW_W-1:0]  put_row_fin;
    logic [COL_W-1:0]  put_col_fin;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign pos_ok = (cmd_reg.row < ROWS_V) && (cmd_reg.col < COLS_V);
    assign is_bs  = (cmd_reg.char_code == CH_BACKSPACE);
    assign is_nl  = (cmd_reg.char_code == CH_NEWLINE);
    assign is_cr  = (cmd_reg.char_code == CH_RETURN);

    always_comb
    begin
        bs_row = cur_row_reg;
        bs_col = cur_col_reg;
        if (cur_col_reg == '0)
        begin
            if (cur_row_reg != '0)
            begin
                bs_row = cur_row_reg - 1'b1;
                bs_col = COL_LAST;
            end
        end
        else
        begin
            bs_col = cur_col_reg - 1'b1;
        end

        put_row = cur_row_reg;
        put_col = cur_col_reg;
        if (is_nl)
        begin
            put_row = cur_row_reg + 1'b1;
            put_col = '0;
        end
        else if (is_cr)
        begin
            put_col = '0;
        end
        else if (cur_col_reg >= COLS_V)
        begin
            put_row = cur_row_reg + 1'b1;
            put_col = '0;
        end
        put_scroll  = (put_row >= ROWS_V);
        put_row_fin = put_scroll ? ROW_LAST : put_row;
        put_col_fin = (is_nl || is_cr) ? put_col : put_col + 1'b1;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = pend_data_reg;
        mem_re    = 1'b0;
        mem_raddr = cnt_reg + COLS_A;
        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {RESET_COLOR, CH_SPACE};
            end
            S_EXEC:
            begin
                mem_re    = (cmd_reg.opcode == OP_READ) && pos_ok;
                mem_raddr = cell_addr(cmd_reg.row, cmd_reg.col);
            end
            S_SCROLL:
            begin
                mem_re    = (cnt_reg < SCROLL_END);
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_reg - 1'b1;
                mem_wdata = mem_rdata_reg;
            end
            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {text_color_reg, CH_SPACE};
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            text_color_reg <= RESET_COLOR;
            cnt_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                text_color_reg <= cfg_wdata;
            end
            if (rsp_valid_reg && rsp_ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_INIT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ADDR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    rch_reg    <= '0;
                    rcol_reg   <= '0;
                    cnt_reg    <= '0;
                    case (cmd_reg.opcode)
                        OP_PUT:
                        begin
                            status_reg <= STATUS_OK;
                            if (is_bs)
                            begin
                                cur_row_reg   <= bs_row;
                                cur_col_reg   <= bs_col;
                                pend_addr_reg <= cell_addr(bs_row, bs_col);
                                pend_data_reg <= {text_color_reg, CH_SPACE};
                                state_reg     <= S_WRITE;
                            end
                            else
                            begin
                                cur_row_reg   <= put_row_fin;
                                cur_col_reg   <= put_col_fin;
                                pend_addr_reg <= cell_addr(put_row_fin, put_col);
                                pend_data_reg <= {text_color_reg, cmd_reg.char_code};
                                state_reg     <= put_scroll ? S_SCROLL : S_WRITE;
                            end
                        end
                        OP_SET:
                        begin
                            status_reg <= pos_ok ? STATUS_OK : STATUS_BAD;
                            state_reg  <= S_DONE;
                            if (pos_ok)
                            begin
                                cur_row_reg <= cmd_reg.row;
                                cur_col_reg <= cmd_reg.col;
                            end
                        end
                        OP_DRAW:
                        begin
                            status_reg <= pos_ok ? STATUS_OK : STATUS_BAD;
                            if (pos_ok)
                            begin
                                pend_addr_reg <= cell_addr(cmd_reg.row, cmd_reg.col);
                                pend_data_reg <= {cmd_reg.draw_color, cmd_reg.char_code};
                                state_reg     <= S_WRITE;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        OP_READ:
                        begin
                            status_reg <= pos_ok ? STATUS_OK : STATUS_BAD;
                            state_reg  <= pos_ok ? S_READ : S_DONE;
                        end
                        OP_CLEAR:
                        begin
                            status_reg  <= STATUS_OK;
                            cur_row_reg <= '0;
                            cur_col_reg <= '0;
                            state_reg   <= S_BLANK;
                        end
                        default:
                        begin
                            status_reg <= STATUS_OK;
                            state_reg  <= S_DONE;
                        end
                    endcase
                end
                S_READ:
                begin
                    rch_reg   <= mem_rdata_reg[BYTE_W-1:0];
                    rcol_reg  <= mem_rdata_reg[CELL_W-1:BYTE_W];
                    state_reg <= S_DONE;
                end
                S_SCROLL:
                begin
                    if (cnt_reg == SCROLL_END)
                    begin
                        state_reg <= S_BLANK;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_BLANK:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ADDR_LAST)
                    begin
                        state_reg <= (cmd_reg.opcode == OP_PUT) ? S_WRITE : S_DONE;
                    end
                end
                S_WRITE:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_valid_reg          <= 1'b1;
                        rsp_reg.status         <= status_reg;
                        rsp_reg.cell_char      <= rch_reg;
                        rsp_reg.cell_color     <= rcol_reg;
                        rsp_reg.cursor_row_now <= cur_row_reg;
                        rsp_reg.cursor_col_now <= cur_col_reg;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- tb/tcce_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tcce_scoreboard_pkg
// Scoreboard for the text console cursor engine. It keeps its own image of
// the screen, the cursor and the text colour, works out the response to each
// accepted command item and compares every response item, field by field,
// with the oldest one outstanding.
// ---------------------------------------------------------------------------
package tcce_scoreboard_pkg;

    import tcce_pkg::*;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    class tcce_scoreboard;

        bit [CELL_W-1:0] screen [NCELLS];
        int              cur_row;
        int              cur_col;
        bit [BYTE_W-1:0] text_color;
        rsp_t            awaited_rsp [$];
        int              mismatches;
        int              results_seen;

        function new();
            for (int i = 0; i < NCELLS; i++)
            begin
                screen[i] = {RESET_COLOR, CH_SPACE};
            end
            cur_row      = 0;
            cur_col      = 0;
            text_color   = RESET_COLOR;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_text_color(bit [BYTE_W-1:0] value);
            text_color = value;
        endfunction

        function void write_cell(int r, int c, bit [BYTE_W-1:0] ch, bit [BYTE_W-1:0] colour);
            if (r < ROWS && c < COLUMNS)
            begin
                screen[r * COLUMNS + c] = {colour, ch};
            end
        endfunction

        function void put_byte(bit [BYTE_W-1:0] ch);
            int r;
            int c;
            r = cur_row;
            c = cur_col;
            if (ch == CH_BACKSPACE)
            begin
                if (c == 0)
                begin
                    if (r > 0)
                    begin
                        r = r - 1;
                        c = COLUMNS - 1;
                    end
                end
                else
                begin
                    c = c - 1;
                end
                write_cell(r, c, CH_SPACE, text_color);
                cur_row = r;
                cur_col = c;
                return;
            end
            if (ch == CH_NEWLINE)
            begin
                r = r + 1;
                c = 0;
            end
            else if (ch == CH_RETURN)
            begin
                c = 0;
            end
            else if (c >= COLUMNS)
            begin
                r = r + 1;
                c = 0;
            end
            if (r >= ROWS)
            begin
                for (int i = 0; i < NCELLS - COLUMNS; i++)
                begin
                    screen[i] = screen[i + COLUMNS];
                end
                for (int i = NCELLS - COLUMNS; i < NCELLS; i++)
                begin
                    screen[i] = {text_color, CH_SPACE};
                end
                r = ROWS - 1;
            end
            write_cell(r, c, ch, text_color);
            if (ch != CH_NEWLINE && ch != CH_RETURN)
            begin
                c = c + 1;
            end
            cur_row = r;
            cur_col = c;
        endfunction

        function rsp_t apply_cmd(cmd_t item);
            rsp_t result;
            bit   in_range;
            result   = '0;
            in_range = (item.row < ROWS) && (item.col < COLUMNS);
            case (item.opcode)
                OP_PUT:
                begin
                    put_byte(item.char_code);
                end
                OP_SET:
                begin
                    if (in_range)
                    begin
                        cur_row = item.row;
                        cur_col = item.col;
                    end
                    else
                    begin
                        result.status = STATUS_BAD;
                    end
                end
                OP_DRAW:
                begin
                    if (in_range)
                    begin
                        write_cell(item.row, item.col, item.char_code, item.draw_color);
                    end
                    else
                    begin
                        result.status = STATUS_BAD;
                    end
                end
                OP_READ:
                begin
                    if (in_range)
                    begin
                        {result.cell_color, result.cell_char} =
                            screen[item.row * COLUMNS + item.col];
                    end
                    else
                    begin
                        result.status = STATUS_BAD;
                    end
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < NCELLS; i++)
                    begin
                        screen[i] = {text_color, CH_SPACE};
                    end
                    cur_row = 0;
                    cur_col = 0;
                end
                default:
                begin
                end
            endcase
            result.cursor_row_now = ROW_W'(cur_row);
            result.cursor_col_now = COL_W'(cur_col);
            return result;
        endfunction

        function void note_cmd(cmd_t item);
            awaited_rsp.push_back(apply_cmd(item));
        endfunction

        function void check_rsp(rsp_t got);
            rsp_t want;
            results_seen++;
            if (awaited_rsp.size() == 0)
            begin
                $error("response item with no command outstanding: %h", got);
                mismatches++;
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.cell_char !== want.cell_char)
            begin
                $error("cell_char: expected %0h, actual %0h", want.cell_char, got.cell_char);
                mismatches++;
            end
            if (got.cell_color !== want.cell_color)
            begin
                $error("cell_color: expected %0h, actual %0h", want.cell_color, got.cell_color);
                mismatches++;
            end
            if (got.cursor_row_now !== want.cursor_row_now)
            begin
                $error("cursor_row_now: expected %0d, actual %0d",
                       want.cursor_row_now, got.cursor_row_now);
                mismatches++;
            end
            if (got.cursor_col_now !== want.cursor_col_now)
            begin
                $error("cursor_col_now: expected %0d, actual %0d",
                       want.cursor_col_now, got.cursor_col_now);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// ----- tb/text_console_cursor_engine_unit_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_console_cursor_engine_unit_tb
// Drives command items into the console engine through a short directed
// sequence and then random text with cursor moves, draws, reads and clears,
// over several text colours, with random stalls on both channels. Every
// response item is checked against the scoreboard's own screen image.
// ---------------------------------------------------------------------------
module text_console_cursor_engine_unit_tb;

    import tcce_pkg::*;
    import tcce_scoreboard_pkg::*;

    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int STEADY_ITEMS    = 200;
    localparam int HOLD_FROM       = 600;
    localparam int HOLD_CYCLES     = 300;
    localparam int STEADY_RSP_LO   = 730;
    localparam int STEADY_RSP_HI   = 930;
    localparam int STALL_LIMIT     = 20000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_ready;
    cmd_t              cmd       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;
    logic              cfg_we    = 1'b0;
    logic [BYTE_W-1:0] cfg_wdata = '0;

    tcce_scoreboard sb = new();
    int             stall_cycles = 0;
    bit             hold_done    = 1'b0;

    text_console_cursor_engine_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                sb.note_cmd(cmd);
            end
            if (rsp_valid && rsp_ready)
            begin
                sb.check_rsp(rsp);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!hold_done && sb.results_seen >= HOLD_FROM)
            begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (sb.results_seen >= STEADY_RSP_LO && sb.results_seen < STEADY_RSP_HI)
            begin
                rsp_ready <= 1'b1;
            end
            else
            begin
                rsp_ready <= ($urandom_range(0, 99) >= 21);
            end
        end
    end

    function automatic cmd_t make_cmd(logic [2:0] op, logic [BYTE_W-1:0] ch,
                                      int r, int c, logic [BYTE_W-1:0] colour);
        cmd_t item;
        item.opcode     = op;
        item.char_code  = ch;
        item.row        = ROW_W'(r);
        item.col        = COL_W'(c);
        item.draw_color = colour;
        return item;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t item;
        int   pick;
        item.char_code  = BYTE_W'($urandom_range(0, 255));
        item.draw_color = BYTE_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            item.row = ROW_W'($urandom_range(0, 31));
        end
        else if (pick < 35)
        begin
            item.row = ROW_W'(ROWS - 1);
        end
        else
        begin
            item.row = ROW_W'($urandom_range(0, ROWS - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            item.col = COL_W'($urandom_range(0, 127));
        end
        else if (pick < 30)
        begin
            item.col = (pick < 25) ? COL_W'(0) : COL_W'(COLUMNS - 1);
        end
        else
        begin
            item.col = COL_W'($urandom_range(0, COLUMNS - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            item.opcode = OP_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                item.char_code = CH_NEWLINE;
            end
            else if (pick < 13)
            begin
                item.char_code = CH_RETURN;
            end
            else if (pick < 21)
            begin
                item.char_code = CH_BACKSPACE;
            end
        end
        else if (pick < 67)
        begin
            item.opcode = OP_SET;
        end
        else if (pick < 79)
        begin
            item.opcode = OP_DRAW;
        end
        else if (pick < 94)
        begin
            item.opcode = OP_READ;
            if ($urandom_range(0, 1) == 1)
            begin
                item.row = ROW_W'(sb.cur_row);
            end
        end
        else if (pick < 95)
        begin
            item.opcode = OP_CLEAR;
        end
        else
        begin
            item.opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        end
        return item;
    endfunction

    task automatic send_cmd(input cmd_t item);
        cmd       <= item;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!(cmd_valid && cmd_ready)) @(posedge clk);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_rsp.size() != 0) @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic change_text_color(input logic [BYTE_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_text_color(value);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_READ, 8'h00, ROWS - 1, COLUMNS - 1, 8'h00));
        send_cmd(make_cmd(OP_READ, 8'h00, ROWS, 0, 8'h00));
        send_cmd(make_cmd(OP_READ, 8'hFF, 31, 127, 8'hFF));
        send_cmd(make_cmd(OP_PUT, CH_BACKSPACE, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_SET, 8'h00, 0, COLUMNS - 1, 8'h00));
        send_cmd(make_cmd(OP_PUT, 8'h41, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_PUT, CH_BACKSPACE, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_PUT, 8'h42, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_PUT, 8'h43, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_SET, 8'h00, 1, 0, 8'h00));
        send_cmd(make_cmd(OP_PUT, CH_BACKSPACE, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_PUT, CH_NEWLINE, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_PUT, CH_RETURN, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_DRAW, 8'hFF, ROWS - 1, COLUMNS - 1, 8'hFF));
        send_cmd(make_cmd(OP_DRAW, 8'h00, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_DRAW, 8'h55, ROWS, COLUMNS, 8'hAA));
        send_cmd(make_cmd(OP_SET, 8'h00, 31, 127, 8'h00));
        send_cmd(make_cmd(OP_SET, 8'h00, 0, COLUMNS, 8'h00));
        send_cmd(make_cmd(OP_SET, 8'h00, ROWS - 1, 10, 8'h00));
        send_cmd(make_cmd(OP_PUT, CH_NEWLINE, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_READ, 8'h00, ROWS - 2, COLUMNS - 1, 8'h00));
        send_cmd(make_cmd(OP_SET, 8'h00, ROWS - 1, COLUMNS - 1, 8'h00));
        send_cmd(make_cmd(OP_PUT, 8'h78, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_PUT, 8'h79, 0, 0, 8'h00));
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
        begin
            send_cmd(make_cmd(3'(op), 8'hFF, 31, 127, 8'hFF));
        end
        send_cmd(make_cmd(OP_CLEAR, 8'h00, 0, 0, 8'h00));
        send_cmd(make_cmd(OP_READ, 8'h00, 0, 0, 8'h00));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 1)
            begin
                change_text_color(8'h00);
            end
            else if (phase == 2)
            begin
                change_text_color(8'hFF);
            end
            else if (phase > 2)
            begin
                change_text_color(BYTE_W'($urandom_range(0, 255)));
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 3 && n == ITEMS_PER_PHASE / 2)
                begin
                    wait_drained();
                end
                if (!(phase == 2 && n < STEADY_ITEMS) && $urandom_range(0, 99) < 21)
                begin
                    cmd_valid <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
                send_cmd(random_cmd());
            end
        end

        wait_drained();
        repeat (NCELLS + 16) @(posedge clk);
        if (sb.awaited_rsp.size() != 0)
        begin
            $error("%0d response items never arrived", sb.awaited_rsp.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/tcce_pkg.sv
sv/text_console_cursor_engine_unit.sv
tb/tcce_scoreboard_pkg.sv
tb/text_console_cursor_engine_unit_tb.sv
